// ----- rtl/bsc_pkg.sv -----
package bsc_pkg;

    // Record layout lengths, in bytes.
    localparam int HDR_LEN     = 12;
    localparam int CH_NAME_LEN = 32;
    localparam int SECRET_LEN  = 16;
    localparam int PUB_LEN     = 32;
    localparam int ALIAS_LEN   = 32;
    localparam int SEED_LEN    = 32;
    localparam int LOC_LEN     = 4;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAGIC    = 2'd0;
    localparam logic [1:0] CFG_MAX_CH   = 2'd1;
    localparam logic [1:0] CFG_MAX_CT   = 2'd2;
    localparam logic [1:0] CFG_RADIO_MAX = 2'd3;

    // Record status codes, reported with the last byte.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_VERSION = 3'd3;
    localparam logic [2:0] ST_CRC     = 3'd4;
    localparam logic [2:0] ST_RANGE   = 3'd5;

    typedef enum logic [3:0] {
        F_HDR     = 4'd0,
        F_CHCNT   = 4'd1,
        F_NAME    = 4'd2,
        F_SECRET  = 4'd3,
        F_CTCNT   = 4'd4,
        F_KEY     = 4'd5,
        F_ALIAS   = 4'd6,
        F_ROLE    = 4'd7,
        F_IDFLAG  = 4'd8,
        F_SEED    = 4'd9,
        F_RLEN    = 4'd10,
        F_RADIO   = 4'd11,
        F_LOCFLAG = 4'd12,
        F_LAT     = 4'd13,
        F_LON     = 4'd14,
        F_IGN     = 4'd15
    } field_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic [3:0] field_tag;
        logic [7:0] entry_index;
        logic [7:0] byte_offset;
        logic       end_of_record;
        logic [2:0] status;
    } out_item_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  max_channels;
        logic [7:0]  max_contacts;
        logic [7:0]  radio_max;
    } cfg_t;

endpackage

// ----- rtl/bsc_crc_byte.sv -----
module bsc_crc_byte (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);
    import bsc_pkg::*;

    // Reflected CRC-32, eight bit steps for one byte.
    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        crc_out = c;
    end

endmodule

// ----- rtl/bsc_decoder.sv -----
module bsc_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  bsc_pkg::in_item_t item,
    input  bsc_pkg::cfg_t     cfg,
    output bsc_pkg::out_item_t result
);
    import bsc_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] stored_crc_reg, stored_crc_next;
    logic        magic_ok_reg, magic_ok_next;
    logic [15:0] version_reg, version_next;
    field_t      field_reg, field_next;
    logic [7:0]  offset_reg, offset_next;
    logic [7:0]  entry_reg, entry_next;
    logic [7:0]  total_reg, total_next;
    logic [7:0]  rblk_size_reg, rblk_size_next;
    logic        range_fault_reg, range_fault_next;

    logic [31:0] crc_upd;
    logic [7:0]  b;
    logic [7:0]  off_inc;
    logic [7:0]  entry_inc;
    logic [7:0]  adv_len;
    logic        adv_done;
    logic [7:0]  magic_byte;
    field_t      tail_field;

    bsc_crc_byte u_crc (
        .crc_in (crc_reg),
        .data   (item.byte_in),
        .crc_out(crc_upd)
    );

    assign b          = item.byte_in;
    assign off_inc    = offset_reg + 8'd1;
    assign entry_inc  = entry_reg + 8'd1;
    assign magic_byte = cfg.magic_word[{offset_reg[1:0], 3'b000} +: 8];
    assign tail_field = (version_reg == 16'd2) ? F_IDFLAG : F_IGN;

    // Length of the multi-byte field being walked.
    always_comb
    begin
        case (field_reg)
            F_HDR:    adv_len = 8'(HDR_LEN);
            F_NAME:   adv_len = 8'(CH_NAME_LEN);
            F_SECRET: adv_len = 8'(SECRET_LEN);
            F_KEY:    adv_len = 8'(PUB_LEN);
            F_ALIAS:  adv_len = 8'(ALIAS_LEN);
            F_SEED:   adv_len = 8'(SEED_LEN);
            F_RADIO:  adv_len = rblk_size_reg;
            F_LAT:    adv_len = 8'(LOC_LEN);
            F_LON:    adv_len = 8'(LOC_LEN);
            default:  adv_len = 8'd0;
        endcase
    end

    assign adv_done = (off_inc >= adv_len);

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        crc_next         = (byte_count_reg >= 16'(HDR_LEN)) ? crc_upd : crc_reg;
        stored_crc_next  = stored_crc_reg;
        magic_ok_next    = magic_ok_reg;
        version_next     = version_reg;
        field_next       = field_reg;
        offset_next      = adv_done ? 8'd0 : off_inc;
        entry_next       = entry_reg;
        total_next       = total_reg;
        rblk_size_next   = rblk_size_reg;
        range_fault_next = range_fault_reg;

        result.data_out      = b;
        result.field_tag     = field_reg;
        result.entry_index   = 8'd0;
        result.byte_offset   = offset_reg;
        result.end_of_record = item.last_byte;
        result.status        = ST_OK;

        case (field_reg)
            F_HDR:
            begin
                if (offset_reg < 8'd4 && b != magic_byte)
                    magic_ok_next = 1'b0;
                if (offset_reg == 8'd4)
                    version_next = {version_reg[15:8], b};
                if (offset_reg == 8'd5)
                    version_next = {b, version_reg[7:0]};
                if (offset_reg >= 8'd8 && offset_reg < 8'd12)
                    stored_crc_next = stored_crc_reg
                                      | ({24'd0, b} << {offset_reg[1:0], 3'b000});
                if (adv_done)
                    field_next = F_CHCNT;
            end
            F_CHCNT:
            begin
                result.byte_offset = 8'd0;
                offset_next        = offset_reg;
                total_next         = b;
                entry_next         = 8'd0;
                if (b > cfg.max_channels)
                begin
                    range_fault_next = 1'b1;
                    field_next       = F_IGN;
                end
                else
                begin
                    field_next = (b == 8'd0) ? F_CTCNT : F_NAME;
                end
            end
            F_NAME:
            begin
                result.entry_index = entry_reg;
                if (offset_reg == 8'(CH_NAME_LEN - 1))
                    result.data_out = 8'd0;
                if (adv_done)
                    field_next = F_SECRET;
            end
            F_SECRET:
            begin
                result.entry_index = entry_reg;
                if (adv_done)
                begin
                    entry_next = entry_inc;
                    field_next = (entry_inc >= total_reg) ? F_CTCNT : F_NAME;
                end
            end
            F_CTCNT:
            begin
                result.byte_offset = 8'd0;
                offset_next        = offset_reg;
                total_next         = b;
                entry_next         = 8'd0;
                if (b > cfg.max_contacts)
                begin
                    range_fault_next = 1'b1;
                    field_next       = F_IGN;
                end
                else if (b == 8'd0)
                begin
                    field_next  = tail_field;
                    offset_next = 8'd0;
                end
                else
                begin
                    field_next = F_KEY;
                end
            end
            F_KEY:
            begin
                result.entry_index = entry_reg;
                if (adv_done)
                    field_next = F_ALIAS;
            end
            F_ALIAS:
            begin
                result.entry_index = entry_reg;
                if (offset_reg == 8'(ALIAS_LEN - 1))
                    result.data_out = 8'd0;
                if (adv_done)
                    field_next = F_ROLE;
            end
            F_ROLE:
            begin
                result.entry_index = entry_reg;
                result.byte_offset = 8'd0;
                offset_next        = offset_reg;
                entry_next         = entry_inc;
                if (entry_inc >= total_reg)
                begin
                    field_next  = tail_field;
                    offset_next = 8'd0;
                end
                else
                begin
                    field_next = F_KEY;
                end
            end
            F_IDFLAG:
            begin
                result.byte_offset = 8'd0;
                result.data_out    = {7'd0, (b != 8'd0)};
                field_next         = (b != 8'd0) ? F_SEED : F_RLEN;
                offset_next        = 8'd0;
            end
            F_SEED:
            begin
                if (adv_done)
                    field_next = F_RLEN;
            end
            F_RLEN:
            begin
                result.byte_offset = 8'd0;
                rblk_size_next     = b;
                offset_next        = 8'd0;
                if (b > cfg.radio_max)
                begin
                    range_fault_next = 1'b1;
                    field_next       = F_IGN;
                end
                else
                begin
                    field_next = (b == 8'd0) ? F_LOCFLAG : F_RADIO;
                end
            end
            F_RADIO:
            begin
                if (adv_done)
                    field_next = F_LOCFLAG;
            end
            F_LOCFLAG:
            begin
                result.byte_offset = 8'd0;
                result.data_out    = {7'd0, (b != 8'd0)};
                field_next         = (b != 8'd0) ? F_LAT : F_IGN;
                offset_next        = 8'd0;
            end
            F_LAT:
            begin
                if (adv_done)
                    field_next = F_LON;
            end
            F_LON:
            begin
                if (adv_done)
                    field_next = F_IGN;
            end
            default:
            begin
                result.byte_offset = 8'd0;
                field_next         = F_IGN;
                offset_next        = 8'd0;
            end
        endcase

        if (byte_count_reg != 16'hFFFF)
            byte_count_next = byte_count_reg + 16'd1;

        if (item.last_byte)
        begin
            if (byte_count_next < 16'(HDR_LEN + 2))
                result.status = ST_SHORT;
            else if (!magic_ok_next)
                result.status = ST_MAGIC;
            else if (version_next != 16'd1 && version_next != 16'd2)
                result.status = ST_VERSION;
            else if (~crc_next != stored_crc_next)
                result.status = ST_CRC;
            else if (range_fault_next
                     || (field_next inside {F_NAME, F_SECRET, F_CTCNT, F_KEY, F_ALIAS,
                                            F_ROLE, F_SEED, F_RADIO, F_LAT, F_LON}))
                result.status = ST_RANGE;
            else
                result.status = ST_OK;

            // Record done: the stream state returns to its idle values.
            byte_count_next  = 16'd0;
            crc_next         = CRC_INIT;
            stored_crc_next  = 32'd0;
            magic_ok_next    = 1'b1;
            version_next     = 16'd0;
            field_next       = F_HDR;
            offset_next      = 8'd0;
            entry_next       = 8'd0;
            total_next       = 8'd0;
            rblk_size_next   = 8'd0;
            range_fault_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= 16'd0;
            crc_reg         <= CRC_INIT;
            stored_crc_reg  <= 32'd0;
            magic_ok_reg    <= 1'b1;
            version_reg     <= 16'd0;
            field_reg       <= F_HDR;
            offset_reg      <= 8'd0;
            entry_reg       <= 8'd0;
            total_reg       <= 8'd0;
            rblk_size_reg   <= 8'd0;
            range_fault_reg <= 1'b0;
        end
        else if (step)
        begin
            byte_count_reg  <= byte_count_next;
            crc_reg         <= crc_next;
            stored_crc_reg  <= stored_crc_next;
            magic_ok_reg    <= magic_ok_next;
            version_reg     <= version_next;
            field_reg       <= field_next;
            offset_reg      <= offset_next;
            entry_reg       <= entry_next;
            total_reg       <= total_next;
            rblk_size_reg   <= rblk_size_next;
            range_fault_reg <= range_fault_next;
        end
    end

endmodule

// ----- rtl/backup_record_stream_checker.sv -----
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------------
// in        | input     | in_valid / in_ready    | in_data  (byte_in, last_byte)
// out       | output    | out_valid / out_ready  | out_data (data_out, field_tag,
//           |           |                        |   entry_index, byte_offset,
//           |           |                        |   end_of_record, status)
// cfg       | input     | cfg_we (no wait)       | cfg_index, cfg_data
//
// A byte's result is offered after its input transfer: the byte waits in the
// input register, and its result then waits in the result register until its
// output transfer. A new byte can be taken every cycle while the output is not
// stalled; the byte-wide CRC update and field counters sit in the one logic
// stage between the two registers. Reset is asynchronous and active low and
// leaves the record parser at the header with no bytes pending. A stall on the
// output holds the result register, and the input register then holds its byte.
module backup_record_stream_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bsc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bsc_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import bsc_pkg::*;

    cfg_t      cfg_reg;
    in_item_t  in_item_reg;
    logic      in_full_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      step;

    // The held byte moves on when the result register is empty or is being
    // drained in this same cycle.
    assign step     = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || step;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Configuration registers. Writes must only come while no record is in flight; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word   <= 32'd0;
            cfg_reg.max_channels <= 8'd8;
            cfg_reg.max_contacts <= 8'd32;
            cfg_reg.radio_max    <= 8'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAGIC:     cfg_reg.magic_word   <= cfg_data;
                CFG_MAX_CH:    cfg_reg.max_channels <= cfg_data[7:0];
                CFG_MAX_CT:    cfg_reg.max_contacts <= cfg_data[7:0];
                CFG_RADIO_MAX: cfg_reg.radio_max    <= cfg_data[7:0];
                default:       cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Input register: takes a transfer whenever it is empty or emptying.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_ready)
            in_full_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
    end

    bsc_decoder u_decoder (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .result(result)
    );

    // Result register: loads on every step, clears once its transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_item_reg <= result;
    end

endmodule
